/* rtl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and the djb2 hash step for the count table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned SlotsDef     = 16;
  localparam int unsigned KeyBytesDef  = 8;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned KeyW         = 64;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountOutW    = 16;
  localparam int unsigned SlotOutW     = 4;
  localparam logic [31:0] HashSeed     = 32'd5381;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_COMPACT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SL_FREE = 2'd0,
    SL_USED = 2'd1,
    SL_DEL  = 2'd2
  } slot_e;

  // one djb2 step: h*33 + b
  function automatic logic [31:0] djb2_step(input logic [31:0] h, input logic [7:0] b);
    djb2_step = (h << 5) + h + {24'd0, b};
  endfunction

endpackage

/* rtl/linear_probe_hash_count_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_count_table
// Open-addressed key counter with linear probing over a synchronous RAM.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)           | tuser
// s_axis  | in  | key[63:0]                    | command[1:0]
// m_axis  | out | count[15:0], slot[19:16]     | status[1:0]
//
// Add, lookup, remove: the key is hashed, reduced modulo Slots and handed
// over, then each probed slot is read (S_PRD) and checked (S_PCHK), up to
// Slots probes. Compact: the scratch RAM is cleared, each used slot is
// rehashed and placed into the scratch RAM with up to Slots probes, then
// all Slots entries are copied back into the main table. After reset a
// clearing pass writes the free state into every entry of both RAMs;
// s_axis_tready stays low meanwhile. One transaction at a time; a finished
// result waits in S_OUT until the output register is free, and no new
// transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
module linear_probe_hash_count_table import lpht_pkg::*; #(
  parameter int unsigned Slots     = SlotsDef,
  parameter int unsigned KeyBytes  = KeyBytesDef,
  parameter int unsigned CountBits = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key[63:0]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // count[15:0], slot[19:16], zero pad
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned AW = $clog2(Slots);
  localparam int unsigned CW = CountBits;
  localparam int unsigned EW = 2 + KeyW + CW;
  localparam logic [CW-1:0] CountMax = {CW{1'b1}};
  localparam logic [AW-1:0] LastSlot = AW'(Slots - 1);

  typedef enum logic [12:0] {
    S_CLEAR = 13'h0001, S_IDLE = 13'h0002, S_HASH = 13'h0004,
    S_PRD   = 13'h0008, S_PCHK = 13'h0010, S_OUT  = 13'h0020,
    S_CRD   = 13'h0040, S_CCHK = 13'h0080, S_CHASH = 13'h0100,
    S_RRD   = 13'h0200, S_RCHK = 13'h0400, S_CPRD = 13'h0800,
    S_CPWR  = 13'h1000
  } state_e;

  state_e state_q, state_d;

  // main table and scratch table, entry = {state, key, count}
  logic [EW-1:0] tab_mem [Slots];
  logic [EW-1:0] reb_mem [Slots];
  logic [EW-1:0] tab_rd_q, reb_rd_q;
  logic [AW-1:0] tab_ra, reb_ra, tab_wa, reb_wa;
  logic          tab_we, reb_we;
  logic [EW-1:0] tab_wd, reb_wd;

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rd_q <= tab_mem[tab_ra];
  end
  always_ff @(posedge clk_i) begin
    if (reb_we) reb_mem[reb_wa] <= reb_wd;
    reb_rd_q <= reb_mem[reb_ra];
  end

  logic [1:0]      t_st, r_st;
  logic [KeyW-1:0] t_key;
  logic [CW-1:0]   t_cnt;
  assign t_st  = tab_rd_q[EW-1 -: 2];
  assign t_key = tab_rd_q[CW +: KeyW];
  assign t_cnt = tab_rd_q[CW-1:0];
  assign r_st  = reb_rd_q[EW-1 -: 2];

  // hash and modulo units
  logic            h_start, h_done, m_done;
  logic [KeyW-1:0] h_key_in, canon;
  logic [31:0]     hash;
  logic [AW-1:0]   home;

  lpht_hash #(.KeyBytes(KeyBytes)) u_hash (
    .clk_i, .rst_ni, .start_i(h_start), .key_i(h_key_in),
    .done_o(h_done), .canon_o(canon), .hash_o(hash)
  );
  lpht_mod #(.Slots(Slots)) u_mod (
    .clk_i, .rst_ni, .start_i(h_done), .hash_i(hash),
    .done_o(m_done), .rem_o(home)
  );

  // working registers
  logic [1:0]      cmd_q, cmd_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [AW-1:0]   a_q, a_d, i_q, i_d, spot_q, spot_d;
  logic [AW:0]     n_q, n_d;
  logic            have_spot_q, have_spot_d, hash_rdy_q, hash_rdy_d;
  logic [CW-1:0]   ccnt_q, ccnt_d;
  logic            ov_q, ov_d;
  logic [1:0]      os_q, os_d;
  logic [CW-1:0]   oc_q, oc_d;
  logic [AW-1:0]   oa_q, oa_d;
  logic [CW-1:0]   inc;

  // output register
  logic [1:0]      res_st_q, res_st_d;
  logic [CW-1:0]   res_cnt_q, res_cnt_d;
  logic [AW-1:0]   res_slot_q, res_slot_d;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
    nxt = (a == LastSlot) ? '0 : a + AW'(1);
  endfunction

  assign inc = (t_cnt == CountMax) ? t_cnt : t_cnt + CW'(1);

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; key_d = key_q; a_d = a_q; i_d = i_q;
    n_d = n_q; spot_d = spot_q; have_spot_d = have_spot_q; ccnt_d = ccnt_q;
    hash_rdy_d = hash_rdy_q;
    ov_d = ov_q; os_d = os_q; oc_d = oc_q; oa_d = oa_q;
    res_st_d = res_st_q; res_cnt_d = res_cnt_q; res_slot_d = res_slot_q;
    tab_ra = a_q; reb_ra = a_q; tab_we = 1'b0; reb_we = 1'b0;
    tab_wa = a_q; reb_wa = a_q; tab_wd = '0; reb_wd = '0;
    h_start = 1'b0; h_key_in = s_axis_tdata;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    if (m_done) hash_rdy_d = 1'b1;
    case (state_q)
      // clear both tables after reset
      S_CLEAR: begin
        tab_we = 1'b1; reb_we = 1'b1; tab_wa = i_q; reb_wa = i_q;
        i_d = nxt(i_q);
        if (i_q == LastSlot) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tuser;
          if (s_axis_tuser == CMD_COMPACT) begin
            i_d = '0; state_d = S_CLEAR;
            // clear scratch first with its own sweep in S_CRD, then gather
            state_d = S_CRD;
            reb_we = 1'b0;
          end else begin
            h_start = 1'b1; hash_rdy_d = 1'b0; state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_rdy_q) begin
          key_d = canon; a_d = home; n_d = '0; have_spot_d = 1'b0;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        tab_ra = a_q; state_d = S_PCHK;
      end
      // one probe step on the main table
      S_PCHK: begin
        state_d = S_PRD;
        if (cmd_q == CMD_ADD && !have_spot_q && t_st != SL_USED) begin
          have_spot_d = 1'b1; spot_d = a_q;
        end
        if (t_st == SL_USED && t_key == key_q) begin
          state_d = S_OUT; os_d = ST_OK; oa_d = a_q;
          case (cmd_q)
            CMD_ADD: begin
              tab_we = 1'b1; tab_wd = {SL_USED, key_q, inc}; oc_d = inc;
            end
            CMD_REMOVE: begin
              tab_we = 1'b1; tab_wd = {SL_DEL, key_q, CW'(0)}; oc_d = '0;
            end
            default: oc_d = t_cnt;
          endcase
        end else if (t_st == SL_FREE || n_q == (AW+1)'(Slots - 1)) begin
          state_d = S_OUT; oc_d = '0; oa_d = '0; os_d = ST_NOTFOUND;
          if (cmd_q == CMD_ADD) begin
            if (have_spot_q || t_st != SL_USED) begin
              tab_we = 1'b1;
              tab_wa = have_spot_q ? spot_q : a_q;
              tab_wd = {SL_USED, key_q, CW'(1)};
              os_d = ST_OK; oc_d = CW'(1); oa_d = tab_wa;
            end else begin
              os_d = ST_FULL;
            end
          end
        end else begin
          a_d = nxt(a_q); n_d = n_q + (AW+1)'(1);
        end
      end
      // hand the result over once the output register is free
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; state_d = S_IDLE;
          res_st_d = os_q; res_cnt_d = oc_q; res_slot_d = oa_q;
        end
      end
      // compact: clear scratch, then gather used entries
      S_CRD: begin
        reb_we = 1'b1; reb_wa = i_q; reb_wd = '0;
        i_d = nxt(i_q);
        if (i_q == LastSlot) begin
          i_d = '0; state_d = S_CCHK; tab_ra = '0;
        end
      end
      S_CCHK: begin
        tab_ra = i_q;
        state_d = S_CHASH;
      end
      S_CHASH: begin
        // tab_rd_q holds entry i
        if (t_st == SL_USED) begin
          h_key_in = t_key; key_d = t_key; ccnt_d = t_cnt;
          h_start = 1'b1; hash_rdy_d = 1'b0; state_d = S_RRD;
        end else if (i_q == LastSlot) begin
          i_d = '0; state_d = S_CPRD;
        end else begin
          i_d = nxt(i_q); state_d = S_CCHK;
        end
      end
      S_RRD: begin
        if (hash_rdy_q) begin
          hash_rdy_d = 1'b0; a_d = home; reb_ra = home; state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (r_st == SL_FREE) begin
          reb_we = 1'b1; reb_wd = {SL_USED, key_q, ccnt_q};
          if (i_q == LastSlot) begin
            i_d = '0; state_d = S_CPRD;
          end else begin
            i_d = nxt(i_q); state_d = S_CCHK;
          end
        end else begin
          a_d = nxt(a_q); reb_ra = nxt(a_q);
        end
      end
      // copy scratch back into the main table
      S_CPRD: begin
        reb_ra = i_q; state_d = S_CPWR;
      end
      S_CPWR: begin
        tab_we = 1'b1; tab_wa = i_q; tab_wd = reb_rd_q;
        if (i_q == LastSlot) begin
          os_d = ST_OK; oc_d = '0; oa_d = '0; state_d = S_OUT;
        end else begin
          i_d = nxt(i_q); state_d = S_CPRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; i_q <= '0; ov_q <= 1'b0; hash_rdy_q <= 1'b0;
    end else begin
      state_q <= state_d; i_q <= i_d; ov_q <= ov_d; hash_rdy_q <= hash_rdy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; key_q <= key_d; a_q <= a_d; n_q <= n_d; spot_q <= spot_d;
    have_spot_q <= have_spot_d; ccnt_q <= ccnt_d;
    os_q <= os_d; oc_q <= oc_d; oa_q <= oa_d;
    res_st_q <= res_st_d; res_cnt_q <= res_cnt_d; res_slot_q <= res_slot_d;
  end

  logic [CountOutW-1:0] oc16;
  logic [SlotOutW-1:0]  oa4;
  assign oc16 = CountOutW'({{32{1'b0}}, res_cnt_q});
  assign oa4  = SlotOutW'({{16{1'b0}}, res_slot_q});

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'd0, oa4, oc16};
  assign m_axis_tuser  = res_st_q;

endmodule

/* rtl/lpht_hash.sv */
// ----------------------------------------------------------------------------
// lpht_hash
// Byte-serial key canonicalization and djb2 hash, one byte per cycle.
// ----------------------------------------------------------------------------
module lpht_hash import lpht_pkg::*; #(
  parameter int unsigned KeyBytes = KeyBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [KeyW-1:0] key_i,
  output logic            done_o,
  output logic [KeyW-1:0] canon_o,
  output logic [31:0]     hash_o
);

  logic [KeyW-1:0] sh_q, sh_d, canon_q, canon_d;
  logic [31:0]     h_q, h_d;
  logic [3:0]      n_q, n_d;
  logic            busy_q, busy_d, done_q, done_d;

  // walk bytes from the most significant end, stop at zero or KeyBytes
  always_comb begin
    sh_d = sh_q; canon_d = canon_q; h_d = h_q; n_d = n_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      sh_d = key_i; canon_d = '0; h_d = HashSeed; n_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (n_q == 4'(KeyBytes) || sh_q[KeyW-1 -: 8] == 8'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        h_d = djb2_step(h_q, sh_q[KeyW-1 -: 8]);
        canon_d = canon_q | ({sh_q[KeyW-1 -: 8], 56'd0} >> {n_q, 3'd0});
        sh_d = sh_q << 8;
        n_d = n_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d; canon_q <= canon_d; h_q <= h_d; n_q <= n_d;
  end

  assign done_o  = done_q;
  assign canon_o = canon_q;
  assign hash_o  = h_q;

endmodule

/* rtl/lpht_mod.sv */
// ----------------------------------------------------------------------------
// lpht_mod
// Hash modulo the slot count: reciprocal multiplication, estimate and correction.
// ----------------------------------------------------------------------------
module lpht_mod import lpht_pkg::*; #(
  parameter int unsigned Slots = SlotsDef,
  localparam int unsigned AW = $clog2(Slots)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   hash_i,
  output logic          done_o,
  output logic [AW-1:0] rem_o
);

  // scaled reciprocal; fits 32 bits since Slots > 2^(AW-1)
  localparam int unsigned Shift  = 31 + AW;
  localparam logic [31:0] Recip  = 32'((64'd1 << Shift) / 64'(Slots));
  localparam logic [AW:0] SlotsC = (AW+1)'(Slots);

  logic [63:0]     prod_q;
  logic [AW:0]     low_q, r_q, r_d, qest;
  logic [2*AW+1:0] qs;
  logic [AW-1:0]   rem_q, rem_d;
  logic            s1_q, s2_q, done_q;

  // quotient estimate is low by at most one: partial remainder below 2*Slots,
  // so its low AW+1 bits are exact and one compare and subtract finishes it
  always_comb begin
    qest  = (AW+1)'(prod_q >> Shift);
    qs    = qest * SlotsC;
    r_d   = low_q - qs[AW:0];
    rem_d = (r_q >= SlotsC) ? AW'(r_q - SlotsC) : r_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0; s2_q <= 1'b0; done_q <= 1'b0;
    end else begin
      s1_q <= start_i; s2_q <= s1_q; done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= hash_i * Recip;
      low_q  <= hash_i[AW:0];
    end
    if (s1_q) r_q <= r_d;
    if (s2_q) rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* bench/linear_probe_hash_count_table_tb.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_count_table_tb
// Drives add, lookup, remove and compact transactions into the count table,
// predicts every result with a behavioral copy of the table and compares
// status, count and slot of each result in order. Both stream sides stall
// at random but for the second directed phase and the last random phase.
// ----------------------------------------------------------------------------
module linear_probe_hash_count_table_tb;
  import lpht_pkg::*;

  localparam int unsigned NSlots   = 16;
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    status_e     status;
    logic [15:0] count;
    logic [3:0]  slot;
  } tbl_result_t;

  // Behavioral copy of the table plus queue of pending results
  class table_scoreboard;
    slot_e       st[NSlots];
    logic [63:0] keys[NSlots];
    logic [15:0] cnt[NSlots];
    tbl_result_t pending[$];
    int          errors;

    function new();
      errors = 0;
      for (int i = 0; i < NSlots; i++) begin
        st[i] = SL_FREE; keys[i] = '0; cnt[i] = '0;
      end
    endfunction

    function logic [63:0] canon(logic [63:0] k);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
        if (k[63-8*i -: 8] == 8'd0) break;
        r[63-8*i -: 8] = k[63-8*i -: 8];
      end
      return r;
    endfunction

    function int home(logic [63:0] k);
      logic [31:0] h;
      h = HashSeed;
      for (int i = 0; i < 8; i++) begin
        if (k[63-8*i -: 8] == 8'd0) break;
        h = (h << 5) + h + {24'd0, k[63-8*i -: 8]};
      end
      return int'(h % NSlots);
    endfunction

    function int find(logic [63:0] k);
      int a;
      a = home(k);
      for (int n = 0; n < NSlots; n++) begin
        if (st[a] == SL_FREE) return -1;
        if (st[a] == SL_USED && keys[a] == k) return a;
        a = (a + 1) % NSlots;
      end
      return -1;
    endfunction

    function void compact();
      slot_e       ns[NSlots];
      logic [63:0] nk[NSlots];
      logic [15:0] nc[NSlots];
      int a;
      for (int i = 0; i < NSlots; i++) begin
        ns[i] = SL_FREE; nk[i] = '0; nc[i] = '0;
      end
      for (int i = 0; i < NSlots; i++) begin
        if (st[i] != SL_USED) continue;
        a = home(keys[i]);
        for (int n = 0; n < NSlots; n++) begin
          if (ns[a] == SL_FREE) begin
            ns[a] = SL_USED; nk[a] = keys[i]; nc[a] = cnt[i];
            break;
          end
          a = (a + 1) % NSlots;
        end
      end
      st = ns; keys = nk; cnt = nc;
    endfunction

    // Predict the result of one accepted transaction
    function void note_input(cmd_e cmd, logic [63:0] raw);
      tbl_result_t r;
      logic [63:0] k;
      int f, a;
      k = canon(raw);
      r = '{status: ST_OK, count: 16'd0, slot: 4'd0};
      case (cmd)
        CMD_ADD: begin
          f = find(k);
          if (f >= 0) begin
            if (cnt[f] < CountMax) cnt[f]++;
            r.count = cnt[f]; r.slot = f[3:0];
          end else begin
            f = -1;
            a = home(k);
            for (int n = 0; n < NSlots; n++) begin
              if (st[a] != SL_USED) begin f = a; break; end
              a = (a + 1) % NSlots;
            end
            if (f < 0) r.status = ST_FULL;
            else begin
              st[f] = SL_USED; keys[f] = k; cnt[f] = 16'd1;
              r.count = 16'd1; r.slot = f[3:0];
            end
          end
        end
        CMD_LOOKUP: begin
          f = find(k);
          if (f < 0) r.status = ST_NOTFOUND;
          else begin r.count = cnt[f]; r.slot = f[3:0]; end
        end
        CMD_REMOVE: begin
          f = find(k);
          if (f < 0) r.status = ST_NOTFOUND;
          else begin st[f] = SL_DEL; cnt[f] = '0; r.slot = f[3:0]; end
        end
        default: compact();
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] status, logic [15:0] count, logic [3:0] slot);
      tbl_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d count=%0d slot=%0d", status, count, slot);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (status != e.status) begin
        $error("status expected %0d actual %0d", e.status, status); errors++;
      end
      if (count != e.count) begin
        $error("count expected %0d actual %0d", e.count, count); errors++;
      end
      if (slot != e.slot) begin
        $error("slot expected %0d actual %0d", e.slot, slot); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // key[63:0]
  logic [1:0]  s_axis_tuser = '0;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // count[15:0], slot[19:16], zero pad
  logic [1:0]  m_axis_tuser;        // status[1:0]

  int unsigned     send_idle_pct = 38;
  int unsigned     recv_idle_pct = 62;
  int unsigned     cycles = 0;
  logic [63:0]     key_pool[8];
  table_scoreboard sb;

  always #6 clk_i = ~clk_i;

  linear_probe_hash_count_table uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Receiver side: random stall, check on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[19:16]);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Send one transaction, with a random gap ahead of it
  task automatic send_cmd(cmd_e cmd, logic [63:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, key);
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    int unsigned len;
    k = {$urandom, $urandom};
    len = $urandom_range(8);
    // mostly short keys with a zero byte; sometimes raw noise past it
    if ($urandom_range(3) != 0)
      for (int i = len; i < 8; i++) k[63-8*i -: 8] = 8'd0;
    return k;
  endfunction

  task automatic run_random(int n);
    int unsigned sel;
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(3) != 0) ? key_pool[$urandom_range(7)] : rand_key();
      sel = $urandom_range(99);
      if (sel < 50)      send_cmd(CMD_ADD, k);
      else if (sel < 75) send_cmd(CMD_LOOKUP, k);
      else if (sel < 95) send_cmd(CMD_REMOVE, k);
      else               send_cmd(CMD_COMPACT, rand_key());
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < 8; i++) key_pool[i] = rand_key();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty key, extremes, tombstone chain, full table, compact
    send_cmd(CMD_LOOKUP, 64'd0);
    send_cmd(CMD_ADD, 64'd0);
    send_cmd(CMD_ADD, 64'h00FF_FFFF_FFFF_FFFF);
    send_cmd(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_ADD, 64'h4100_0000_0000_0000);
    send_cmd(CMD_ADD, 64'h4142_0000_0000_0000);
    send_cmd(CMD_REMOVE, 64'd0);
    send_cmd(CMD_ADD, 64'h4142_0000_0000_0000);
    send_cmd(CMD_LOOKUP, 64'h4142_00AA_5500_1234);
    send_cmd(CMD_REMOVE, 64'h4142_0000_0000_0000);
    send_cmd(CMD_REMOVE, 64'h4142_0000_0000_0000);
    send_cmd(CMD_COMPACT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(CMD_LOOKUP, 64'h4100_0000_0000_0000);
    for (int i = 0; i < 18; i++) send_cmd(CMD_ADD, {8'h30 + i[7:0], 56'd0});
    send_cmd(CMD_REMOVE, 64'h3100_0000_0000_0000);
    send_cmd(CMD_ADD, 64'h3500_0000_0000_0000);
    send_cmd(CMD_COMPACT, 64'd0);
    drain();

    // Repeated hits on one key after removing keys 0x30 to 0x3F, no stalls
    send_idle_pct = 0; recv_idle_pct = 0;
    send_cmd(CMD_COMPACT, 64'd0);
    for (int i = 0; i < 16; i++) send_cmd(CMD_REMOVE, {8'h30 + i[7:0], 56'd0});
    send_cmd(CMD_COMPACT, 64'd0);
    for (int i = 0; i < 20; i++) send_cmd(CMD_ADD, 64'h5A00_0000_0000_0000);
    send_cmd(CMD_LOOKUP, 64'h5A00_0000_0000_0000);
    drain();

    send_idle_pct = 38; recv_idle_pct = 62;
    run_random(160);
    drain();
    send_idle_pct = 62; recv_idle_pct = 38;
    run_random(160);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(170);

    drain();
    repeat (2 * NSlots * (2 * NSlots + 47)) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lpht_pkg.sv
rtl/lpht_hash.sv
rtl/lpht_mod.sv
rtl/linear_probe_hash_count_table.sv
bench/linear_probe_hash_count_table_tb.sv
